### design/ntkl_pkg.sv
// Package for the nibble trie key lookup block.
// Action codes, fixed field widths and the table write request type.
// No dependencies.
`default_nettype none

package ntkl_pkg;

  localparam int NIB_W   = 4;
  localparam int FANOUT  = 16;
  localparam int CHILD_W = 10;
  localparam int INFO_W  = 16;
  localparam int TLEN_W  = 5;
  localparam int TBITS_W = 64;

  typedef enum logic [1:0] {
    ACT_WR_CHILD = 2'd0,
    ACT_WR_ATTR  = 2'd1,
    ACT_LOOKUP   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // one write request into the node table
  typedef struct packed {
    logic                 child_we;
    logic                 attr_we;
    logic [CHILD_W-1:0]   node;
    logic [NIB_W-1:0]     slot;
    logic [CHILD_W-1:0]   child;
    logic                 has_info;
    logic [INFO_W-1:0]    info;
    logic [TLEN_W-1:0]    tag_len;
    logic [TBITS_W-1:0]   tag_bits;
  } wr_t;

endpackage

`default_nettype wire

### design/ntkl_if.sv
// Valid/ready channel interfaces for the nibble trie key lookup block.
// Request channel (writes and lookup characters) and response channel.
// No dependencies.
`default_nettype none

interface ntkl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  node_index;
  logic [3:0]  nibble_slot;
  logic [9:0]  child_node;
  logic        has_info;
  logic [15:0] info_value;
  logic [4:0]  tag_length;
  logic [63:0] tag_bits;
  logic [7:0]  key_char;
  logic        key_last;

  modport source (
    output valid, action, node_index, nibble_slot, child_node, has_info,
           info_value, tag_length, tag_bits, key_char, key_last,
    input  ready
  );
  modport sink (
    input  valid, action, node_index, nibble_slot, child_node, has_info,
           info_value, tag_length, tag_bits, key_char, key_last,
    output ready
  );
endinterface

interface ntkl_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_id;
  logic [9:0]  end_node;

  modport source (output valid, found, match_id, end_node, input ready);
  modport sink   (input valid, found, match_id, end_node, output ready);
endinterface

`default_nettype wire

### design/ntkl_table.sv
// Node table: child pointer rows and node attributes in synchronous RAM.
// Clearing sweep after reset, one node row per cycle. Uses ntkl_pkg.
`default_nettype none

module ntkl_table #(
  parameter int NUM_NODES       = 1024,
  parameter int TAG_NIBBLES_MAX = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ntkl_pkg::wr_t                              wr,
  input  logic [$clog2(NUM_NODES)-1:0]               rd_addr,
  output logic                                       busy,
  output logic [ntkl_pkg::FANOUT*ntkl_pkg::CHILD_W-1:0] child_row,
  output logic                                       info_valid,
  output logic [ntkl_pkg::INFO_W-1:0]                info_id,
  output logic [$clog2(TAG_NIBBLES_MAX+1)-1:0]       tag_len,
  output logic [4*TAG_NIBBLES_MAX-1:0]               tag_bits
);
  import ntkl_pkg::*;

  localparam int NIDX_W = $clog2(NUM_NODES);
  localparam int LEN_W  = $clog2(TAG_NIBBLES_MAX + 1);
  localparam int TAG_W  = NIB_W * TAG_NIBBLES_MAX;
  localparam int ROW_W  = FANOUT * CHILD_W;
  localparam int ATTR_W = 1 + INFO_W + LEN_W + TAG_W;

  function automatic logic [TBITS_W-1:0] tag_mask(input logic [TLEN_W-1:0] len);
    logic [TBITS_W-1:0] m;
    if (len >= TLEN_W'(16)) begin
      m = '1;
    end else begin
      m = (TBITS_W'(1) << {len[3:0], 2'b00}) - TBITS_W'(1);
    end
    return m;
  endfunction

  logic [ROW_W-1:0]  child_mem [NUM_NODES];
  logic [ATTR_W-1:0] attr_mem  [NUM_NODES];

  logic [NIDX_W-1:0] clr_addr;
  logic [NIDX_W-1:0] waddr;
  logic              in_range;
  logic [LEN_W-1:0]  sat_len;
  logic [TAG_W-1:0]  wr_tag;
  logic [ATTR_W-1:0] attr_q;

  assign waddr    = NIDX_W'(wr.node);
  assign in_range = 32'(wr.node) < NUM_NODES;
  assign sat_len  = (32'(wr.tag_len) > TAG_NIBBLES_MAX) ? LEN_W'(TAG_NIBBLES_MAX)
                                                         : LEN_W'(wr.tag_len);
  assign wr_tag   = TAG_W'(wr.tag_bits & tag_mask(TLEN_W'(sat_len)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == NIDX_W'(NUM_NODES - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      child_mem[clr_addr] <= '0;
    end else if (wr.child_we && in_range) begin
      child_mem[waddr][wr.slot*CHILD_W +: CHILD_W] <= wr.child;
    end
    child_row <= child_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      attr_mem[clr_addr] <= '0;
    end else if (wr.attr_we && in_range) begin
      attr_mem[waddr] <= {wr.has_info, wr.info, sat_len, wr_tag};
    end
    attr_q <= attr_mem[rd_addr];
  end

  assign {info_valid, info_id, tag_len, tag_bits} = attr_q;

endmodule

`default_nettype wire

### design/ntkl_step.sv
// Shared nibble step unit: tag collect, tag compare and child select.
// Used once per nibble by the sequencer. Uses ntkl_pkg.
`default_nettype none

module ntkl_step #(
  parameter int NUM_NODES       = 1024,
  parameter int TAG_NIBBLES_MAX = 16
) (
  input  logic [ntkl_pkg::NIB_W-1:0]                    nib,
  input  logic [$clog2(NUM_NODES)-1:0]                  cur_node,
  input  logic [4*TAG_NIBBLES_MAX-1:0]                  pend_bits,
  input  logic [$clog2(TAG_NIBBLES_MAX+1)-1:0]          pend_cnt,
  input  logic                                          missed,
  input  logic [$clog2(TAG_NIBBLES_MAX+1)-1:0]          tag_len,
  input  logic [4*TAG_NIBBLES_MAX-1:0]                  tag_bits,
  input  logic [ntkl_pkg::FANOUT*ntkl_pkg::CHILD_W-1:0] child_row,
  output logic                                          tag_match,
  output logic [$clog2(NUM_NODES)-1:0]                  nxt_node,
  output logic [4*TAG_NIBBLES_MAX-1:0]                  nxt_bits,
  output logic [$clog2(TAG_NIBBLES_MAX+1)-1:0]          nxt_cnt,
  output logic                                          nxt_missed
);
  import ntkl_pkg::*;

  localparam int NIDX_W = $clog2(NUM_NODES);
  localparam int TAG_W  = NIB_W * TAG_NIBBLES_MAX;

  logic [CHILD_W-1:0] child;

  assign tag_match = (pend_cnt == tag_len) && (pend_bits == tag_bits);
  assign child     = child_row[nib*CHILD_W +: CHILD_W];

  always_comb begin
    nxt_node   = cur_node;
    nxt_bits   = pend_bits;
    nxt_cnt    = pend_cnt;
    nxt_missed = missed;
    if (!missed) begin
      if (tag_len > pend_cnt) begin
        nxt_bits = (pend_bits << NIB_W) | TAG_W'(nib);
        nxt_cnt  = pend_cnt + 1'b1;
      end else begin
        nxt_bits = '0;
        nxt_cnt  = '0;
        if (!tag_match) begin
          nxt_missed = 1'b1;
        end else if (child == '0 || 32'(child) >= NUM_NODES) begin
          // no child: miss, stay put
          nxt_missed = 1'b1;
        end else begin
          nxt_node = NIDX_W'(child);
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/nibble_trie_key_lookup.sv
// Top level of the nibble trie key lookup block: sequencer and response register.
// Uses ntkl_pkg, ntkl_if, ntkl_table, ntkl_step.
//
//   channel | dir | carries
//   req     | in  | table writes (child, attributes) and lookup key bytes
//   rsp     | out | found, match_id, end_node at the last key byte
//
// A key byte is walked as two nibbles: the high nibble in the accept cycle,
// the low nibble in the next, each on one registered node-table read.
// After the last byte the end node is read out in ST_FIN, which holds while rsp stalls.
// A table write passes through ST_WSYNC so the next read sees the new entry.
// After reset the table is cleared, one node per cycle, with req.ready low.
`default_nettype none

module nibble_trie_key_lookup #(
  parameter int NUM_NODES       = 1024,
  parameter int TAG_NIBBLES_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  ntkl_req_if.sink    req,
  ntkl_rsp_if.source  rsp
);
  import ntkl_pkg::*;

  localparam int NIDX_W = $clog2(NUM_NODES);
  localparam int LEN_W  = $clog2(TAG_NIBBLES_MAX + 1);
  localparam int TAG_W  = NIB_W * TAG_NIBBLES_MAX;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WSYNC = 5'b00100,
    ST_LO    = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [NIDX_W-1:0]  cur_node, cur_node_next;
  logic [TAG_W-1:0]   pend_bits, pend_bits_next;
  logic [LEN_W-1:0]   pend_cnt, pend_cnt_next;
  logic               missed, missed_next;
  logic [NIB_W-1:0]   lo_nib;
  logic               last;

  logic               accept;
  wr_t                wr;
  logic               busy;
  logic [FANOUT*CHILD_W-1:0] child_row;
  logic               info_valid;
  logic [INFO_W-1:0]  info_id;
  logic [LEN_W-1:0]   tag_len;
  logic [TAG_W-1:0]   tag_bits;

  logic [NIB_W-1:0]   nib;
  logic               tag_match;
  logic [NIDX_W-1:0]  s_node;
  logic [TAG_W-1:0]   s_bits;
  logic [LEN_W-1:0]   s_cnt;
  logic               s_missed;

  logic               load_rsp;
  logic               reached;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    wr.child_we = accept && (action_t'(req.action) == ACT_WR_CHILD);
    wr.attr_we  = accept && (action_t'(req.action) == ACT_WR_ATTR);
    wr.node     = req.node_index;
    wr.slot     = req.nibble_slot;
    wr.child    = req.child_node;
    wr.has_info = req.has_info;
    wr.info     = req.info_value;
    wr.tag_len  = req.tag_length;
    wr.tag_bits = req.tag_bits;
  end

  ntkl_table #(
    .NUM_NODES       (NUM_NODES),
    .TAG_NIBBLES_MAX (TAG_NIBBLES_MAX)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .rd_addr    (cur_node_next),
    .busy       (busy),
    .child_row  (child_row),
    .info_valid (info_valid),
    .info_id    (info_id),
    .tag_len    (tag_len),
    .tag_bits   (tag_bits)
  );

  assign nib = (state == ST_IDLE) ? req.key_char[7:4] : lo_nib;

  ntkl_step #(
    .NUM_NODES       (NUM_NODES),
    .TAG_NIBBLES_MAX (TAG_NIBBLES_MAX)
  ) u_step (
    .nib        (nib),
    .cur_node   (cur_node),
    .pend_bits  (pend_bits),
    .pend_cnt   (pend_cnt),
    .missed     (missed),
    .tag_len    (tag_len),
    .tag_bits   (tag_bits),
    .child_row  (child_row),
    .tag_match  (tag_match),
    .nxt_node   (s_node),
    .nxt_bits   (s_bits),
    .nxt_cnt    (s_cnt),
    .nxt_missed (s_missed)
  );

  assign reached  = !missed && tag_match;
  assign load_rsp = (state == ST_FIN) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next     = state;
    cur_node_next  = cur_node;
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    missed_next    = missed;
    unique case (state)
      ST_CLEAR: begin
        if (!busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(req.action)) inside
            ACT_WR_CHILD, ACT_WR_ATTR: state_next = ST_WSYNC;
            ACT_LOOKUP: begin
              cur_node_next  = s_node;
              pend_bits_next = s_bits;
              pend_cnt_next  = s_cnt;
              missed_next    = s_missed;
              state_next     = ST_LO;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WSYNC: begin
        state_next = ST_IDLE;
      end
      ST_LO: begin
        cur_node_next  = s_node;
        pend_bits_next = s_bits;
        pend_cnt_next  = s_cnt;
        missed_next    = s_missed;
        state_next     = last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (load_rsp) begin
          // key done: walk restarts at the root
          cur_node_next  = '0;
          pend_bits_next = '0;
          pend_cnt_next  = '0;
          missed_next    = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur_node  <= '0;
      pend_bits <= '0;
      pend_cnt  <= '0;
      missed    <= 1'b0;
    end else begin
      state     <= state_next;
      cur_node  <= cur_node_next;
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
      missed    <= missed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_nib <= req.key_char[3:0];
      last   <= req.key_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.found    <= reached && info_valid;
      rsp.match_id <= (reached && info_valid) ? info_id : '0;
      rsp.end_node <= reached ? CHILD_W'(cur_node) : '0;
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_nibble_trie_key_lookup.sv
// Testbench for nibble_trie_key_lookup: table writes and key lookups with a
// scoreboard, random valid/ready gaps and one long response stall.
// Depends on ntkl_pkg, ntkl_req_if / ntkl_rsp_if and the design top level.
`default_nettype none

module tb_nibble_trie_key_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import ntkl_pkg::*;

  localparam int  CYCLE_LIMIT  = 250000;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  HOLD_AFTER   = 40;
  localparam int  DRAIN_CYCLES = 24;
  localparam int  RAND_ITEMS   = 1250;
  localparam int  MAX_TAG      = 16;

  typedef struct {
    action_t     act;
    logic [9:0]  node;
    logic [3:0]  slot;
    logic [9:0]  child;
    logic        has_info;
    logic [15:0] info;
    logic [4:0]  tlen;
    logic [63:0] tbits;
    logic [7:0]  kchar;
    logic        klast;
  } req_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] id;
    logic [9:0]  node;
  } answer_t;

  logic clk;
  logic rst;

  ntkl_req_if req_ch ();
  ntkl_rsp_if rsp_ch ();

  nibble_trie_key_lookup i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // trie image and lookup walk state
  logic [9:0]  child_ptr     [16384];
  logic        node_has_info [1024];
  logic [15:0] node_info_id  [1024];
  logic [4:0]  node_tlen     [1024];
  logic [63:0] node_tbits    [1024];
  logic [9:0]  walk_node;
  logic [63:0] walk_tag;
  logic [4:0]  walk_cnt;
  logic        walk_dead;

  req_item_t req_pend_q [$];
  answer_t   answer_q [$];
  req_item_t req_cur;

  int errors       = 0;
  int real_items   = 0;
  int n_writes     = 0;
  int n_key_bytes  = 0;
  int n_results    = 0;
  int n_found      = 0;
  int cycle_cnt    = 0;
  int send_gap     = 0;
  int send_left    = 0;
  bit send_calm    = 0;
  int recv_wait    = 0;
  int recv_left    = 0;
  bit recv_calm    = 0;
  logic hold_on;
  logic hold_done;
  int   hold_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic note_error(input string msg);
    if (errors < 50) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // gap length for one side; alternates stretches of no idling with busy ones
  function automatic int pick_gap(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(10, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic tag_matches(logic [9:0] n);
    return (walk_cnt == node_tlen[n]) && (walk_tag == node_tbits[n]);
  endfunction

  function automatic void take_nibble(logic [3:0] nib);
    logic [9:0] nxt;
    logic       ok;
    if (walk_dead) return;
    if (node_tlen[walk_node] > walk_cnt) begin
      walk_tag = {walk_tag[59:0], nib};
      walk_cnt = walk_cnt + 5'd1;
      return;
    end
    ok = tag_matches(walk_node);
    walk_tag = '0;
    walk_cnt = '0;
    if (!ok) begin
      walk_dead = 1'b1;
      return;
    end
    nxt = child_ptr[{walk_node, nib}];
    // a null child ends the walk as a miss; it never goes back to the root
    if (nxt == '0) walk_dead = 1'b1;
    else walk_node = nxt;
  endfunction

  function automatic void apply_request(req_item_t it);
    int      len;
    answer_t a;
    logic    reached;
    case (it.act)
      ACT_WR_CHILD: begin
        child_ptr[{it.node, it.slot}] = it.child;
        n_writes++;
      end
      ACT_WR_ATTR: begin
        len = (it.tlen > MAX_TAG) ? MAX_TAG : int'(it.tlen);
        node_has_info[it.node] = it.has_info;
        node_info_id[it.node]  = it.info;
        node_tlen[it.node]     = 5'(len);
        node_tbits[it.node]    = (len == MAX_TAG) ? it.tbits :
                                 it.tbits & ((64'd1 << (4 * len)) - 64'd1);
        n_writes++;
      end
      ACT_LOOKUP: begin
        n_key_bytes++;
        take_nibble(it.kchar[7:4]);
        take_nibble(it.kchar[3:0]);
        if (it.klast) begin
          reached = !walk_dead && tag_matches(walk_node);
          a.found = reached && node_has_info[walk_node];
          a.id    = a.found ? node_info_id[walk_node] : 16'd0;
          a.node  = reached ? walk_node : 10'd0;
          answer_q.push_back(a);
          walk_node = '0;
          walk_tag  = '0;
          walk_cnt  = '0;
          walk_dead = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic req_item_t rand_item();
    req_item_t it;
    it.act      = action_t'($urandom_range(0, 3));
    it.node     = 10'($urandom);
    it.slot     = 4'($urandom);
    it.child    = 10'($urandom);
    it.has_info = 1'($urandom);
    it.info     = 16'($urandom);
    it.tlen     = 5'($urandom);
    it.tbits    = {$urandom, $urandom};
    it.kchar    = 8'($urandom);
    it.klast    = 1'($urandom);
    return it;
  endfunction

  task automatic queue_request(input req_item_t it);
    req_pend_q.push_back(it);
    if (it.act != ACT_NONE) real_items++;
  endtask

  task automatic queue_child(input logic [9:0] node, input logic [3:0] slot,
                             input logic [9:0] child);
    req_item_t it;
    it       = rand_item();
    it.act   = ACT_WR_CHILD;
    it.node  = node;
    it.slot  = slot;
    it.child = child;
    queue_request(it);
  endtask

  task automatic queue_attr(input logic [9:0] node, input logic has,
                            input logic [15:0] info, input logic [4:0] tlen,
                            input logic [63:0] tbits);
    req_item_t it;
    it          = rand_item();
    it.act      = ACT_WR_ATTR;
    it.node     = node;
    it.has_info = has;
    it.info     = info;
    it.tlen     = tlen;
    it.tbits    = tbits;
    queue_request(it);
  endtask

  // occasionally slips a stray write or idle request in front of the key byte
  task automatic queue_byte(input logic [7:0] ch, input logic last);
    req_item_t it;
    if ($urandom_range(0, 11) == 0) begin
      it = rand_item();
      if (it.act == ACT_LOOKUP) it.act = ACT_NONE;
      queue_request(it);
    end
    it       = rand_item();
    it.act   = ACT_LOOKUP;
    it.kchar = ch;
    it.klast = last;
    queue_request(it);
  endtask

  // builds a chain of nodes from the root, then looks up its key, mostly exact
  task automatic grow_path_and_probe();
    logic [3:0]  nibs [$];
    logic [9:0]  here;
    logic [9:0]  nxt;
    logic [3:0]  sl;
    logic [63:0] tb;
    int          depth;
    int          lvl;
    int          len;
    int          raw;
    int          pick;
    int          idx;
    int          k;
    depth = $urandom_range(0, 4);
    here  = '0;
    for (lvl = 0; lvl <= depth; lvl++) begin
      pick = $urandom_range(0, 9);
      len  = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 4) : $urandom_range(5, 16);
      if (lvl == depth) begin
        if (((nibs.size() + len) % 2) != 0) len = (len < MAX_TAG) ? len + 1 : len - 1;
        if (nibs.size() + len == 0) len = 2;
      end
      raw = len;
      if (len == MAX_TAG && $urandom_range(0, 1) == 1) raw = $urandom_range(17, 31);
      tb = {$urandom, $urandom};
      queue_attr(here, (lvl == depth) ? ($urandom_range(0, 4) != 0) : 1'($urandom),
                 16'($urandom), 5'(raw), tb);
      for (k = 0; k < len; k++) nibs.push_back(tb[4 * (len - 1 - k) +: 4]);
      if (lvl < depth) begin
        sl  = 4'($urandom);
        nxt = 10'($urandom_range(1, 1023));
        queue_child(here, sl, nxt);
        nibs.push_back(sl);
        here = nxt;
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        idx = $urandom_range(0, nibs.size() - 1);
        nibs[idx] = nibs[idx] ^ 4'($urandom_range(1, 15));
      end
      1: if (nibs.size() >= 4) begin
        void'(nibs.pop_back());
        void'(nibs.pop_back());
      end
      2: begin
        nibs.push_back(4'($urandom));
        nibs.push_back(4'($urandom));
      end
      default: ;
    endcase
    for (k = 0; k < nibs.size(); k += 2)
      queue_byte({nibs[k], nibs[k + 1]}, k + 2 >= nibs.size());
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_request(req_cur);
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_pend_q.size() > 0) begin
          req_cur = req_pend_q.pop_front();
          req_ch.action      <= req_cur.act;
          req_ch.node_index  <= req_cur.node;
          req_ch.nibble_slot <= req_cur.slot;
          req_ch.child_node  <= req_cur.child;
          req_ch.has_info    <= req_cur.has_info;
          req_ch.info_value  <= req_cur.info;
          req_ch.tag_length  <= req_cur.tlen;
          req_ch.tag_bits    <= req_cur.tbits;
          req_ch.key_char    <= req_cur.kchar;
          req_ch.key_last    <= req_cur.klast;
          req_ch.valid       <= 1'b1;
          send_gap = pick_gap(send_left, send_calm);
          // keep requests coming while the response side is held off
          if (hold_on) send_gap = 0;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results++;
        if (answer_q.size() == 0) begin
          note_error("response with no lookup outstanding");
        end else begin
          want = answer_q.pop_front();
          if (want.found) n_found++;
          if (rsp_ch.found !== want.found)
            note_error($sformatf("found %0b, expected %0b", rsp_ch.found, want.found));
          if (rsp_ch.match_id !== want.id)
            note_error($sformatf("match_id %h, expected %h", rsp_ch.match_id, want.id));
          if (rsp_ch.end_node !== want.node)
            note_error($sformatf("end_node %0d, expected %0d", rsp_ch.end_node, want.node));
        end
        recv_wait = pick_gap(recv_left, recv_calm);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      rsp_ch.ready <= (recv_wait == 0) && !hold_on;
    end
  end

  // one long response stall so the block backs up into the request side
  always @(posedge clk) begin
    if (rst) begin
      hold_on   <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (!hold_done && n_results >= HOLD_AFTER) begin
      hold_on   <= 1'b1;
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
    end else if (hold_on) begin
      if (hold_cnt == 0) hold_on <= 1'b0;
      else hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d requests still queued",
               cycle_cnt, req_pend_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int pick;
    int k;
    int nbytes;
    req_item_t it;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_NONE;
    req_ch.node_index  = '0;
    req_ch.nibble_slot = '0;
    req_ch.child_node  = '0;
    req_ch.has_info    = 1'b0;
    req_ch.info_value  = '0;
    req_ch.tag_length  = '0;
    req_ch.tag_bits    = '0;
    req_ch.key_char    = '0;
    req_ch.key_last    = 1'b0;
    rsp_ch.ready       = 1'b0;
    hold_on            = 1'b0;
    for (k = 0; k < 16384; k++) child_ptr[k] = '0;
    for (k = 0; k < 1024; k++) begin
      node_has_info[k] = 1'b0;
      node_info_id[k]  = '0;
      node_tlen[k]     = '0;
      node_tbits[k]    = '0;
    end
    walk_node = '0;
    walk_tag  = '0;
    walk_cnt  = '0;
    walk_dead = 1'b0;

    // directed: empty table, root tag, deep saturated tag, early key ends
    queue_byte(8'hA5, 1'b1);
    queue_attr(10'd0, 1'b1, 16'hFFFF, 5'd2, 64'hFFFF_FFFF_FFFF_FFA5);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'hA4, 1'b1);
    queue_attr(10'd0, 1'b0, 16'h1234, 5'd0, 64'hDEAD_BEEF_0000_0001);
    queue_child(10'd0, 4'hF, 10'd1023);
    queue_child(10'd1023, 4'h0, 10'd1);
    queue_byte(8'hF0, 1'b1);
    queue_attr(10'd1, 1'b1, 16'h8001, 5'd31, 64'h0123_4567_89AB_CDEF);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h23, 1'b0);
    queue_byte(8'h45, 1'b0);
    queue_byte(8'h67, 1'b0);
    queue_byte(8'h89, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'hCD, 1'b0);
    queue_byte(8'hEF, 1'b1);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'hF0, 1'b1);
    queue_byte(8'h0F, 1'b1);
    it     = rand_item();
    it.act = ACT_NONE;
    queue_request(it);

    while (real_items < RAND_ITEMS + 25) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        grow_path_and_probe();
      end else if (pick < 18) begin
        nbytes = $urandom_range(1, 3);
        for (k = 0; k < nbytes; k++) queue_byte(8'($urandom), k == nbytes - 1);
      end else begin
        queue_request(rand_item());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (req_pend_q.size() != 0 || req_ch.valid);
    while (answer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (answer_q.size() != 0)
      note_error($sformatf("%0d responses never arrived", answer_q.size()));

    $display("Run covered %0d table writes and %0d key bytes; %0d lookup responses checked,",
             n_writes, n_key_bytes, n_results);
    $display("%0d of them hits, with one %0d-cycle response stall; %0d mismatches",
             n_found, HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
